// ===== hw/rtl/ppr_pkg.sv =====
// Shared constants, codes and types of the reorder permutation block.
package ppr_pkg;

  localparam int MAX_VARS = 64;
  localparam int MAX_LIST = 64;
  localparam int VAR_W    = 6;
  localparam int CNT_W    = 7;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_LONG  = 2'd3;

  localparam logic [1:0] REG_MODE_PUSH = 2'd0;
  localparam logic [1:0] REG_PERM_SIZE = 2'd1;
  localparam logic [1:0] REG_SKIP_DUP  = 2'd2;

  typedef struct packed {
    logic             mode_push;
    logic [CNT_W-1:0] perm_size;
    logic             skip_duplicates;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic [VAR_W-1:0] waddr;
    logic [VAR_W-1:0] wdata;
    logic [VAR_W-1:0] raddr;
  } ram_port_t;

endpackage

// ===== hw/rtl/ppr_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module ppr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ppr_cfg.sv =====
// Configuration register file behind the APB-style port.
module ppr_cfg import ppr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[3:2];
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode_push       <= 1'b0;
      cfg.perm_size       <= CNT_W'(MAX_VARS);
      cfg.skip_duplicates <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_MODE_PUSH: cfg.mode_push       <= pwdata[0];
        REG_PERM_SIZE: cfg.perm_size       <= pwdata[CNT_W-1:0];
        REG_SKIP_DUP:  cfg.skip_duplicates <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_index)
      REG_MODE_PUSH: prdata[0]         = cfg.mode_push;
      REG_PERM_SIZE: prdata[CNT_W-1:0] = cfg.perm_size;
      REG_SKIP_DUP:  prdata[0]         = cfg.skip_duplicates;
      default:       prdata            = '0;
    endcase
  end

endmodule

// ===== hw/rtl/ppr_ctrl.sv =====
// Sequencer that loads the list, scans it against the mark map, fills and emits.
module ppr_ctrl import ppr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             item_valid,
  output logic             item_stall,
  input  logic [VAR_W-1:0] var_index,
  input  logic             list_end,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [VAR_W-1:0] slot,
  output logic [VAR_W-1:0] entry,
  output logic [1:0]       status,
  output logic             run_end,
  output ram_port_t        list_port,
  input  logic [VAR_W-1:0] list_rdata,
  output ram_port_t        slot_port,
  input  logic [VAR_W-1:0] slot_rdata
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FILL  = 3'd2;
  localparam logic [2:0] S_PRIME = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]          state, state_next;
  logic [CNT_W-1:0]    list_count, list_count_next;
  logic                err_long, err_long_next;
  logic [1:0]          err_code, err_code_next;
  logic                rd_valid, rd_valid_next;
  logic [CNT_W-1:0]    rem, rem_next;
  logic [CNT_W-1:0]    uniq, uniq_next;
  logic [MAX_VARS-1:0] mark, mark_next;
  logic                res_valid, res_valid_next;
  logic [VAR_W-1:0]    cur_idx, cur_idx_next;

  logic [CNT_W-1:0]    n_eff, n_eff_next;
  logic                mode, mode_next;
  logic                skip, skip_next;
  logic [VAR_W-1:0]    scan_addr, scan_addr_next;
  logic [CNT_W-1:0]    fill_v, fill_v_next;
  logic [VAR_W-1:0]    fill_pos, fill_pos_next;

  logic [CNT_W-1:0]    n_clamp;
  logic                is_last;
  logic                out_take;

  always_comb begin
    if (cfg.perm_size == '0) begin
      n_clamp = CNT_W'(1);
    end else if (cfg.perm_size > CNT_W'(MAX_VARS)) begin
      n_clamp = CNT_W'(MAX_VARS);
    end else begin
      n_clamp = cfg.perm_size;
    end
  end

  assign is_last  = (err_code != ST_OK) || ({1'b0, cur_idx} == n_eff - CNT_W'(1));
  assign out_take = res_valid && !result_stall;

  assign item_stall   = (state != S_LOAD);
  assign result_valid = res_valid;
  assign slot         = cur_idx;
  assign entry        = (err_code != ST_OK) ? '0 : slot_rdata;
  assign status       = err_code;
  assign run_end      = is_last;

  always_comb begin
    state_next      = state;
    list_count_next = list_count;
    err_long_next   = err_long;
    err_code_next   = err_code;
    rd_valid_next   = 1'b0;
    rem_next        = rem;
    uniq_next       = uniq;
    mark_next       = mark;
    res_valid_next  = res_valid;
    cur_idx_next    = cur_idx;
    n_eff_next      = n_eff;
    mode_next       = mode;
    skip_next       = skip;
    scan_addr_next  = scan_addr;
    fill_v_next     = fill_v;
    fill_pos_next   = fill_pos;
    list_port       = '0;
    slot_port       = '0;
    slot_port.raddr = cur_idx;

    unique case (state)
      S_LOAD: begin
        if (item_valid) begin
          if (list_count < CNT_W'(MAX_LIST)) begin
            list_port.we    = 1'b1;
            list_port.waddr = list_count[VAR_W-1:0];
            list_port.wdata = var_index;
            list_count_next = list_count + CNT_W'(1);
          end else begin
            err_long_next = 1'b1;
          end
          if (list_end) begin
            n_eff_next = n_clamp;
            mode_next  = cfg.mode_push;
            skip_next  = cfg.skip_duplicates;
            if (err_long || list_count == CNT_W'(MAX_LIST)) begin
              err_code_next  = ST_LONG;
              cur_idx_next   = '0;
              res_valid_next = 1'b1;
              state_next     = S_EMIT;
            end else begin
              rem_next       = list_count + CNT_W'(1);
              scan_addr_next = cfg.mode_push ? list_count[VAR_W-1:0] : '0;
              uniq_next      = '0;
              state_next     = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        if (rem != '0) begin
          list_port.raddr = scan_addr;
          scan_addr_next  = mode ? scan_addr - VAR_W'(1) : scan_addr + VAR_W'(1);
          rem_next        = rem - CNT_W'(1);
          rd_valid_next   = 1'b1;
        end
        if (rd_valid) begin
          if ({1'b0, list_rdata} >= n_eff) begin
            err_code_next = ST_RANGE;
          end else if (mark[list_rdata]) begin
            if (!skip) begin
              err_code_next = ST_DUP;
            end
          end else begin
            mark_next[list_rdata] = 1'b1;
            slot_port.we    = 1'b1;
            slot_port.waddr = mode ? VAR_W'(n_eff - CNT_W'(1) - uniq) : uniq[VAR_W-1:0];
            slot_port.wdata = list_rdata;
            uniq_next       = uniq + CNT_W'(1);
          end
          if (err_code_next != ST_OK) begin
            mark_next      = '0;
            cur_idx_next   = '0;
            res_valid_next = 1'b1;
            rd_valid_next  = 1'b0;
            state_next     = S_EMIT;
          end else if (rem == '0) begin
            fill_v_next   = '0;
            fill_pos_next = mode ? '0 : uniq_next[VAR_W-1:0];
            state_next    = S_FILL;
          end
        end
      end

      S_FILL: begin
        if (!mark[fill_v[VAR_W-1:0]]) begin
          slot_port.we    = 1'b1;
          slot_port.waddr = fill_pos;
          slot_port.wdata = fill_v[VAR_W-1:0];
          fill_pos_next   = fill_pos + VAR_W'(1);
        end
        fill_v_next = fill_v + CNT_W'(1);
        if (fill_v == n_eff - CNT_W'(1)) begin
          mark_next  = '0;
          state_next = S_PRIME;
        end
      end

      S_PRIME: begin
        slot_port.raddr = '0;
        cur_idx_next    = '0;
        res_valid_next  = 1'b1;
        state_next      = S_EMIT;
      end

      S_EMIT: begin
        if (out_take) begin
          if (is_last) begin
            res_valid_next  = 1'b0;
            list_count_next = '0;
            err_long_next   = 1'b0;
            err_code_next   = ST_OK;
            uniq_next       = '0;
            state_next      = S_LOAD;
          end else begin
            cur_idx_next    = cur_idx + VAR_W'(1);
            slot_port.raddr = cur_idx + VAR_W'(1);
          end
        end
      end

      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      list_count <= '0;
      err_long   <= 1'b0;
      err_code   <= ST_OK;
      rd_valid   <= 1'b0;
      rem        <= '0;
      uniq       <= '0;
      mark       <= '0;
      res_valid  <= 1'b0;
      cur_idx    <= '0;
    end else begin
      state      <= state_next;
      list_count <= list_count_next;
      err_long   <= err_long_next;
      err_code   <= err_code_next;
      rd_valid   <= rd_valid_next;
      rem        <= rem_next;
      uniq       <= uniq_next;
      mark       <= mark_next;
      res_valid  <= res_valid_next;
      cur_idx    <= cur_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    n_eff     <= n_eff_next;
    mode      <= mode_next;
    skip      <= skip_next;
    scan_addr <= scan_addr_next;
    fill_v    <= fill_v_next;
    fill_pos  <= fill_pos_next;
  end

endmodule

// ===== hw/rtl/pull_push_reorder_permutation_top.sv =====
// Top level of the pull/push reorder permutation builder.
// List words load at one per cycle while in the load state. The end-marked word
// starts a scan over the list RAM, a fill pass over the mark map, a prime step for
// the slot RAM read, then N result words at one per cycle while the output is not
// stalled. An error ends the scan early (an overlong list skips it) and gives a
// single status word. Synchronous reset clears the control state and the mark map.
module pull_push_reorder_permutation_top import ppr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [VAR_W-1:0]  var_index,
  input  logic              list_end,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [VAR_W-1:0]  slot,
  output logic [VAR_W-1:0]  entry,
  output logic [1:0]        status,
  output logic              run_end
);

  cfg_t             cfg;
  ram_port_t        list_port;
  ram_port_t        slot_port;
  logic [VAR_W-1:0] list_rdata;
  logic [VAR_W-1:0] slot_rdata;

  ppr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ppr_ram #(.WIDTH(VAR_W), .DEPTH(MAX_LIST)) u_list_ram (
    .clk   (clk),
    .we    (list_port.we),
    .waddr (list_port.waddr),
    .wdata (list_port.wdata),
    .raddr (list_port.raddr),
    .rdata (list_rdata)
  );

  ppr_ram #(.WIDTH(VAR_W), .DEPTH(MAX_VARS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_port.we),
    .waddr (slot_port.waddr),
    .wdata (slot_port.wdata),
    .raddr (slot_port.raddr),
    .rdata (slot_rdata)
  );

  ppr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .var_index    (var_index),
    .list_end     (list_end),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .slot         (slot),
    .entry        (entry),
    .status       (status),
    .run_end      (run_end),
    .list_port    (list_port),
    .list_rdata   (list_rdata),
    .slot_port    (slot_port),
    .slot_rdata   (slot_rdata)
  );

endmodule

// ===== test/ppr_checker.sv =====
// Checker for the reorder permutation block: predicts each list run and compares result words.
module ppr_checker import ppr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic [DATA_W-1:0] prdata,
  input  logic              pready,
  input  logic              item_valid,
  input  logic              item_stall,
  input  logic [VAR_W-1:0]  var_index,
  input  logic              list_end,
  input  logic              result_valid,
  input  logic              result_stall,
  input  logic [VAR_W-1:0]  slot,
  input  logic [VAR_W-1:0]  entry,
  input  logic [1:0]        status,
  input  logic              run_end,
  output int unsigned       fail_count,
  output int unsigned       words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VAR_W-1:0] slot;
    logic [VAR_W-1:0] entry;
    logic [1:0]       status;
    logic             run_end;
  } perm_word_t;

  perm_word_t       permutation_due[$];
  logic [VAR_W-1:0] listed[MAX_LIST];
  int unsigned      listed_n;
  logic [1:0]       overflow_code;
  cfg_t             cfg;

  initial begin
    fail_count = 0;
    words_due = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t ns: %s is %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Builds the permutation of the run just closed, or its single status word.
  task automatic build_permutation();
    logic [VAR_W-1:0]    order[MAX_VARS];
    logic [MAX_VARS-1:0] marked;
    int unsigned         n, next, j, idx;
    logic [1:0]          st;
    perm_word_t          w;
    n = 32'(cfg.perm_size);
    if (n < 1) n = 1;
    if (n > MAX_VARS) n = MAX_VARS;
    marked = '0;
    st = ST_OK;
    for (j = 0; j < MAX_VARS; j++) order[j] = '0;
    if (overflow_code != ST_OK) begin
      st = overflow_code;
    end else begin
      if (!cfg.mode_push) begin
        next = 0;
        for (j = 0; j < listed_n && st == ST_OK; j++) begin
          idx = 32'(listed[j]);
          if (idx >= n) begin
            st = ST_RANGE;
          end else if (marked[idx]) begin
            if (!cfg.skip_duplicates) st = ST_DUP;
          end else begin
            marked[idx] = 1'b1;
            order[next] = idx[VAR_W-1:0];
            next++;
          end
        end
      end else begin
        // The last occurrences fill the top slots downward.
        next = n;
        for (j = listed_n; j > 0 && st == ST_OK; j--) begin
          idx = 32'(listed[j-1]);
          if (idx >= n) begin
            st = ST_RANGE;
          end else if (marked[idx]) begin
            if (!cfg.skip_duplicates) st = ST_DUP;
          end else begin
            marked[idx] = 1'b1;
            order[(next - 1) % MAX_VARS] = idx[VAR_W-1:0];
            next--;
          end
        end
        next = 0;
      end
      for (idx = 0; idx < n && st == ST_OK; idx++) begin
        if (!marked[idx]) begin
          order[next] = idx[VAR_W-1:0];
          next++;
        end
      end
    end
    listed_n = 0;
    overflow_code = ST_OK;
    if (st != ST_OK) begin
      w = '{slot: '0, entry: '0, status: st, run_end: 1'b1};
      permutation_due.push_back(w);
    end else begin
      for (j = 0; j < n; j++) begin
        w = '{slot: j[VAR_W-1:0], entry: order[j], status: ST_OK, run_end: (j + 1 == n)};
        permutation_due.push_back(w);
      end
    end
  endtask

  always @(posedge clk) begin
    perm_word_t w;
    if (rst) begin
      permutation_due.delete();
      listed_n = 0;
      overflow_code = ST_OK;
      cfg.mode_push = 1'b0;
      cfg.perm_size = CNT_W'(MAX_VARS);
      cfg.skip_duplicates = 1'b0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[ADDR_W-1:2])
            REG_MODE_PUSH: cfg.mode_push = pwdata[0];
            REG_PERM_SIZE: cfg.perm_size = pwdata[CNT_W-1:0];
            REG_SKIP_DUP:  cfg.skip_duplicates = pwdata[0];
            default: ;
          endcase
        end else begin
          case (paddr[ADDR_W-1:2])
            REG_MODE_PUSH:
              if (prdata !== DATA_W'(cfg.mode_push))
                report_mismatch("mode_push readback", prdata, 32'(cfg.mode_push));
            REG_PERM_SIZE:
              if (prdata !== DATA_W'(cfg.perm_size))
                report_mismatch("perm_size readback", prdata, 32'(cfg.perm_size));
            REG_SKIP_DUP:
              if (prdata !== DATA_W'(cfg.skip_duplicates))
                report_mismatch("skip_duplicates readback", prdata,
                                32'(cfg.skip_duplicates));
            default: ;
          endcase
        end
      end
      if (item_valid && !item_stall) begin
        if (listed_n < MAX_LIST) begin
          listed[listed_n] = var_index;
          listed_n++;
        end else begin
          overflow_code = ST_LONG;
        end
        if (list_end) build_permutation();
      end
      if (result_valid && !result_stall) begin
        if (permutation_due.size() == 0) begin
          report_mismatch("unexpected word, slot", 32'(slot), 0);
        end else begin
          w = permutation_due.pop_front();
          if (slot !== w.slot) report_mismatch("slot", 32'(slot), 32'(w.slot));
          if (entry !== w.entry) report_mismatch("entry", 32'(entry), 32'(w.entry));
          if (status !== w.status) report_mismatch("status", 32'(status), 32'(w.status));
          if (run_end !== w.run_end)
            report_mismatch("run_end", 32'(run_end), 32'(w.run_end));
        end
      end
    end
    words_due <= permutation_due.size();
  end

endmodule

// ===== test/tb_pull_push_reorder_permutation_top.sv =====
// Testbench top: drives list runs and register settings into the block and gives the verdict.
module tb_pull_push_reorder_permutation_top import ppr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ITEM_TARGET   = 310;
  localparam int          SETTLE_CYCLES = 3 * MAX_VARS + MAX_LIST + 16;
  localparam int unsigned LIMIT_CYCLES  = 5_000_000;
  localparam logic [1:0]  REG_UNUSED    = 2'd3;

  typedef enum {RUN_CLEAN, RUN_REPEAT, RUN_RANGE, RUN_NOISE, RUN_LONG} run_kind_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              item_valid = 1'b0;
  logic              item_stall;
  logic [VAR_W-1:0]  var_index = '0;
  logic              list_end = 1'b0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [VAR_W-1:0]  slot;
  logic [VAR_W-1:0]  entry;
  logic [1:0]        status;
  logic              run_end;
  int unsigned       fail_count;
  int unsigned       words_due;

  int unsigned       cycle_count = 0;
  int unsigned       stall_hold = 0;
  int                items_sent = 0;
  bit                steady_run;
  logic              cur_push;
  logic [CNT_W-1:0]  cur_size;
  logic              cur_skip;
  logic [VAR_W-1:0]  run_words[$];

  pull_push_reorder_permutation_top DUT (.*);
  ppr_checker checker_i (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: short random stalls, with occasional long stalls and calm stretches.
  always @(negedge clk) begin
    int pick;
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        result_stall <= 1'b0;
        stall_hold <= $urandom_range(30, 80);
      end else if (pick == 1) begin
        result_stall <= 1'b1;
        stall_hold <= $urandom_range(10, 40);
      end else begin
        result_stall <= ($urandom_range(0, 2) == 0);
        stall_hold <= $urandom_range(0, 3);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (steady_run || r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int eff_size();
    if (cur_size == 0) return 1;
    if (cur_size > MAX_VARS) return MAX_VARS;
    return int'(cur_size);
  endfunction

  function automatic logic [CNT_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return CNT_W'($urandom_range(1, 16));
    if (r < 16) return CNT_W'($urandom_range(17, MAX_VARS - 1));
    if (r < 18) return CNT_W'(MAX_VARS);
    if (r == 18) return '0;
    return CNT_W'($urandom_range(MAX_VARS + 1, 127));
  endfunction

  function automatic run_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 19);
    if (r < 11) return RUN_CLEAN;
    if (r < 14) return RUN_REPEAT;
    if (r < 17) return RUN_RANGE;
    if (r < 19) return RUN_NOISE;
    return ($urandom_range(0, 2) == 0) ? RUN_LONG : RUN_CLEAN;
  endfunction

  task automatic apb_access(input logic write, input logic [1:0] idx,
                            input logic [DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic push, input logic [CNT_W-1:0] size, input logic skip);
    apb_access(1'b1, REG_MODE_PUSH, DATA_W'(push));
    apb_access(1'b1, REG_PERM_SIZE, DATA_W'(size));
    apb_access(1'b1, REG_SKIP_DUP, DATA_W'(skip));
    apb_access(1'b0, REG_MODE_PUSH, '0);
    apb_access(1'b0, REG_PERM_SIZE, '0);
    apb_access(1'b0, REG_SKIP_DUP, '0);
    cur_push = push;
    cur_size = size;
    cur_skip = skip;
  endtask

  task automatic send_word(input logic [VAR_W-1:0] idx, input logic last);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    var_index <= idx;
    list_end <= last;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic send_run();
    int k;
    steady_run = ($urandom_range(0, 3) == 0);
    for (k = 0; k < run_words.size(); k++) send_word(run_words[k], k == run_words.size() - 1);
    items_sent += run_words.size();
  endtask

  task automatic wait_idle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic make_run(input run_kind_t kind);
    logic [VAR_W-1:0] pool[MAX_VARS];
    logic [VAR_W-1:0] tmp;
    int               n, len, k, j;
    n = eff_size();
    run_words.delete();
    case (kind)
      RUN_NOISE, RUN_LONG: begin
        len = (kind == RUN_LONG) ? $urandom_range(MAX_LIST + 1, MAX_LIST + 4)
                                 : $urandom_range(1, 8);
        repeat (len) run_words.push_back(VAR_W'($urandom_range(0, MAX_VARS - 1)));
      end
      default: begin
        for (k = 0; k < n; k++) pool[k] = VAR_W'(k);
        for (k = n - 1; k > 0; k--) begin
          j = $urandom_range(0, k);
          tmp = pool[k];
          pool[k] = pool[j];
          pool[j] = tmp;
        end
        len = $urandom_range(1, n);
        for (k = 0; k < len; k++) run_words.push_back(pool[k]);
        if (kind == RUN_REPEAT) begin
          repeat (cur_skip ? $urandom_range(1, 3) : 1) begin
            tmp = run_words[$urandom_range(0, run_words.size() - 1)];
            run_words.insert($urandom_range(0, run_words.size()), tmp);
          end
        end
        if (kind == RUN_RANGE && n < MAX_VARS) begin
          run_words.insert($urandom_range(0, run_words.size()),
                           VAR_W'($urandom_range(n, MAX_VARS - 1)));
        end
      end
    endcase
  endtask

  initial begin
    int        runs;
    bit        long_pending;
    run_kind_t kind;
    cur_push = 1'b0;
    cur_size = CNT_W'(MAX_VARS);
    cur_skip = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: read back, then plain, single-word and repeated-index runs.
    apb_access(1'b0, REG_MODE_PUSH, '0);
    apb_access(1'b0, REG_PERM_SIZE, '0);
    apb_access(1'b0, REG_SKIP_DUP, '0);
    run_words = '{6'd63, 6'd0, 6'd21};
    send_run();
    run_words = '{6'd42};
    send_run();
    run_words = '{6'd5, 6'd5};
    send_run();
    wait_idle();

    // Push mode with skipping; a write to the unused address must change nothing.
    set_config(1'b1, 7'd8, 1'b1);
    apb_access(1'b1, REG_UNUSED, $urandom);
    apb_access(1'b0, REG_PERM_SIZE, '0);
    run_words = '{6'd3, 6'd7, 6'd3, 6'd1};
    send_run();
    run_words = '{6'd8};
    send_run();
    run_words = '{6'd6, 6'd60, 6'd6};
    send_run();
    wait_idle();

    // A size of zero behaves as one.
    set_config(1'b0, 7'd0, 1'b0);
    run_words = '{6'd0};
    send_run();
    run_words = '{6'd1};
    send_run();
    wait_idle();

    // A size above the maximum behaves as the maximum.
    set_config(1'b1, 7'd127, 1'b0);
    run_words = '{6'd2, 6'd9, 6'd2};
    send_run();
    run_words = '{6'd63, 6'd0};
    send_run();
    wait_idle();

    // With two errors in one list, the first in scan order is reported.
    set_config(1'b0, 7'd16, 1'b0);
    run_words = '{6'd40, 6'd3, 6'd3};
    send_run();
    wait_idle();

    long_pending = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      set_config(1'($urandom_range(0, 1)), pick_size(), 1'($urandom_range(0, 1)));
      runs = $urandom_range(2, 4);
      repeat (runs) begin
        if (long_pending) begin
          kind = RUN_LONG;
          long_pending = 1'b0;
        end else begin
          kind = pick_kind();
        end
        make_run(kind);
        send_run();
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
